@@ rtl/utld_pkg.sv @@
`default_nettype none

package utld_pkg;

    // Field widths
    localparam int EPOCH_W  = 32;
    localparam int ZONE_W   = 16;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;

    // Internal widths
    localparam int BIASED_W = 33;   // epoch + offset + bias, always positive
    localparam int DAYS_W   = 16;   // whole days of the biased sum
    localparam int SOD_W    = 17;   // seconds of day
    localparam int Z_W      = 20;   // days since 0000-03-01
    localparam int DOE_W    = 18;   // day of era
    localparam int YOE_W    = 9;    // year of era
    localparam int DOY_W    = 9;    // day of March-based year
    localparam int MP_W     = 4;    // March-based month

    // Pipeline depth split
    localparam int FRONT_STAGES = 3;
    localparam int CIVIL_STAGES = 7;
    localparam int LATENCY      = FRONT_STAGES + CIVIL_STAGES;
    localparam int HM_DLY       = CIVIL_STAGES - 3;

    // Calendar constants
    localparam logic [BIASED_W-1:0] BIAS_SECONDS = 33'd2592000;   // 30 days
    localparam logic [Z_W-1:0]      Z_SHIFT      = 20'd719438;    // 719468 - 30
    localparam logic [Z_W-1:0]      ERA5_START   = 20'd730485;    // 5 * 146097
    localparam logic [Z_W-1:0]      ERA4_START   = 20'd584388;    // 4 * 146097
    localparam logic [YEAR_W-1:0]   ERA5_YEAR    = 12'd2000;
    localparam logic [YEAR_W-1:0]   ERA4_YEAR    = 12'd1600;

    // Exact reciprocal multipliers: q = (x * M) >> S for the full input range
    localparam logic [26:0] MUL_675  = 27'd101806633;  // S = 36, x < 2^26
    localparam int          SH_675   = 36;
    localparam logic [18:0] MUL_1460 = 19'd367720;     // S = 29, x < 2^18
    localparam int          SH_1460  = 29;
    localparam logic [18:0] MUL_365  = 19'd367720;     // S = 27, x < 2^18
    localparam int          SH_365   = 27;
    localparam logic [11:0] MUL_153  = 12'd3427;       // S = 19, x < 2^11
    localparam int          SH_153   = 19;
    localparam logic [11:0] MUL_5    = 12'd3277;       // S = 14, x < 2^11
    localparam int          SH_5     = 14;
    localparam logic [17:0] MUL_3600 = 18'd149131;     // S = 29, x < 2^17
    localparam int          SH_3600  = 29;
    localparam logic [12:0] MUL_60   = 13'd4370;       // S = 18, x < 2^12
    localparam int          SH_60    = 18;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_hm;

endpackage

`default_nettype wire

@@ rtl/utld_ifs.sv @@
`default_nettype none

interface utld_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [utld_pkg::EPOCH_W-1:0]    epoch_seconds;
    logic signed [utld_pkg::ZONE_W-1:0]     zone_offset_minutes;

    modport source (output valid, output epoch_seconds, output zone_offset_minutes,
                    input ready);
    modport sink   (input valid, input epoch_seconds, input zone_offset_minutes,
                    output ready);
endinterface

interface utld_out_if;
    logic                              valid;
    logic                              ready;
    logic [utld_pkg::YEAR_W-1:0]       year;
    logic [utld_pkg::MONTH_W-1:0]      month;
    logic [utld_pkg::DAY_W-1:0]        day;
    logic [utld_pkg::HOUR_W-1:0]       hour;
    logic [utld_pkg::MINUTE_W-1:0]     minute;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, output ready);
endinterface

`default_nettype wire

@@ rtl/utld_civil.sv @@
`default_nettype none

// Day number (days since 0000-03-01) to Gregorian year, month, day.
// Seven register stages, advancing together on i_en.
module utld_civil (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [utld_pkg::Z_W-1:0]       i_z,
    output logic [utld_pkg::YEAR_W-1:0]    o_year,
    output logic [utld_pkg::MONTH_W-1:0]   o_month,
    output logic [utld_pkg::DAY_W-1:0]     o_day
);

    localparam int DW = utld_pkg::DOE_W;
    localparam int YW = utld_pkg::YOE_W;
    localparam int QW = utld_pkg::DOY_W;
    localparam int MW = utld_pkg::MP_W;

    // stage 1
    logic          r_era5_1, n_era5_1;
    logic [DW-1:0] r_doe_1,  n_doe_1;
    // stage 2
    logic          r_era5_2;
    logic [DW-1:0] r_doe_2;
    logic [6:0]    r_a_2,    n_a_2;
    logic [2:0]    r_b_2,    n_b_2;
    logic          r_c_2,    n_c_2;
    // stage 3
    logic          r_era5_3;
    logic [DW-1:0] r_doe_3;
    logic [DW-1:0] r_t_3,    n_t_3;
    // stage 4
    logic          r_era5_4;
    logic [DW-1:0] r_doe_4;
    logic [YW-1:0] r_yoe_4,  n_yoe_4;
    // stage 5
    logic          r_era5_5;
    logic [YW-1:0] r_yoe_5;
    logic [QW-1:0] r_doy_5,  n_doy_5;
    // stage 6
    logic          r_era5_6;
    logic [YW-1:0] r_yoe_6;
    logic [QW-1:0] r_doy_6;
    logic [MW-1:0] r_mp_6,   n_mp_6;
    // stage 7
    logic [utld_pkg::YEAR_W-1:0]  r_year,  n_year;
    logic [utld_pkg::MONTH_W-1:0] r_month, n_month;
    logic [utld_pkg::DAY_W-1:0]   r_day,   n_day;

    logic [36:0] w_pa;
    logic [36:0] w_py;
    logic [DW-1:0] w_sub;
    logic [1:0]  w_c100;
    logic [10:0] w_x153;
    logic [22:0] w_pm;
    logic [10:0] w_x5;
    logic [22:0] w_pd;
    logic [QW-1:0] w_dsub;

    always_comb begin
        // era is 4 or 5 for every reachable day number
        n_era5_1 = (i_z >= utld_pkg::ERA5_START);
        n_doe_1  = DW'(i_z - (n_era5_1 ? utld_pkg::ERA5_START : utld_pkg::ERA4_START));

        w_pa  = 37'(r_doe_1) * 37'(utld_pkg::MUL_1460);
        n_a_2 = w_pa[utld_pkg::SH_1460 +: 7];
        n_b_2 = 3'(r_doe_1 >= 18'd36524) + 3'(r_doe_1 >= 18'd73048)
              + 3'(r_doe_1 >= 18'd109572) + 3'(r_doe_1 >= 18'd146096);
        n_c_2 = (r_doe_1 == 18'd146096);

        n_t_3 = r_doe_2 - DW'(r_a_2) + DW'(r_b_2) - DW'(r_c_2);

        w_py    = 37'(r_t_3) * 37'(utld_pkg::MUL_365);
        n_yoe_4 = w_py[utld_pkg::SH_365 +: YW];

        if (r_yoe_4 >= 9'd300) begin
            w_c100 = 2'd3;
        end else if (r_yoe_4 >= 9'd200) begin
            w_c100 = 2'd2;
        end else if (r_yoe_4 >= 9'd100) begin
            w_c100 = 2'd1;
        end else begin
            w_c100 = 2'd0;
        end
        w_sub   = DW'(r_yoe_4) * DW'(365) + DW'(r_yoe_4 >> 2) - DW'(w_c100);
        n_doy_5 = QW'(r_doe_4 - w_sub);

        w_x153 = {r_doy_5, 2'b00} + 11'(r_doy_5) + 11'd2;
        w_pm   = 23'(w_x153) * 23'(utld_pkg::MUL_153);
        n_mp_6 = w_pm[utld_pkg::SH_153 +: MW];

        w_x5   = 11'(r_mp_6) * 11'd153 + 11'd2;
        w_pd   = 23'(w_x5) * 23'(utld_pkg::MUL_5);
        w_dsub = w_pd[utld_pkg::SH_5 +: QW];
        n_day  = utld_pkg::DAY_W'(r_doy_6 - w_dsub + 9'd1);
        // March-based month back to January-based
        if (r_mp_6 < 4'd10) begin
            n_month = r_mp_6 + 4'd3;
        end else begin
            n_month = r_mp_6 - 4'd9;
        end
        n_year = utld_pkg::YEAR_W'(r_yoe_6)
               + (r_era5_6 ? utld_pkg::ERA5_YEAR : utld_pkg::ERA4_YEAR)
               + utld_pkg::YEAR_W'(n_month <= 4'd2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_era5_1 <= n_era5_1;
            r_doe_1  <= n_doe_1;

            r_era5_2 <= r_era5_1;
            r_doe_2  <= r_doe_1;
            r_a_2    <= n_a_2;
            r_b_2    <= n_b_2;
            r_c_2    <= n_c_2;

            r_era5_3 <= r_era5_2;
            r_doe_3  <= r_doe_2;
            r_t_3    <= n_t_3;

            r_era5_4 <= r_era5_3;
            r_doe_4  <= r_doe_3;
            r_yoe_4  <= n_yoe_4;

            r_era5_5 <= r_era5_4;
            r_yoe_5  <= r_yoe_4;
            r_doy_5  <= n_doy_5;

            r_era5_6 <= r_era5_5;
            r_yoe_6  <= r_yoe_5;
            r_doy_6  <= r_doy_5;
            r_mp_6   <= n_mp_6;

            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

endmodule

`default_nettype wire

@@ rtl/unix_time_to_local_date_core.sv @@
`default_nettype none

// Throughput: one word per cycle unless the output word waits for ready; ten register stages,
// each holding one constant-reciprocal multiply or one add and compare, advance together.
// Backpressure: the whole pipeline holds while the output word waits for ready.
// Reset: i_rst_n is synchronous and active low; it clears the stage valid bits only.
module unix_time_to_local_date_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utld_in_if.sink            i_in,
    utld_out_if.source         o_out
);

    localparam int LAT = utld_pkg::LATENCY;
    localparam int BW  = utld_pkg::BIASED_W;

    logic [LAT-1:0] r_vld;
    logic           w_en;

    // front stages
    logic [BW-1:0]              r_biased, n_biased;
    logic [25:0]                r_x;
    logic [6:0]                 r_lo;
    logic [utld_pkg::DAYS_W-1:0] r_qd, n_qd;
    logic [utld_pkg::SOD_W-1:0] r_rem, n_rem;
    logic [utld_pkg::Z_W-1:0]   r_z, n_z;

    // hour and minute
    logic [utld_pkg::SOD_W-1:0]    r_rem_h1;
    logic [utld_pkg::HOUR_W-1:0]   r_hour_1, n_hour_1;
    logic [utld_pkg::HOUR_W-1:0]   r_hour_2;
    logic [11:0]                   r_mr_2, n_mr_2;
    logic [utld_pkg::MINUTE_W-1:0] n_minute;
    utld_pkg::t_hm                 r_hm_dly [utld_pkg::HM_DLY+1];

    logic signed [22:0] w_off60;
    logic [22:0]        w_off_ext;
    logic [52:0]        w_pq;
    logic [25:0]        w_r;
    logic [34:0]        w_ph;
    logic [24:0]        w_pmin;

    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        w_off_ext = {{7{i_in.zone_offset_minutes[15]}}, i_in.zone_offset_minutes};
        w_off60   = signed'((w_off_ext << 6) - (w_off_ext << 2));
        // modular sum; the true value is positive and below 2^33
        n_biased  = BW'({1'b0, i_in.epoch_seconds}) + BW'(w_off60)
                  + utld_pkg::BIAS_SECONDS;
        if (w_off60[22]) begin
            n_biased = BW'({1'b0, i_in.epoch_seconds})
                     + {{(BW-23){1'b1}}, w_off60} + utld_pkg::BIAS_SECONDS;
        end

        // 86400 = 128 * 675
        w_pq = 53'(r_biased[BW-1:7]) * 53'(utld_pkg::MUL_675);
        n_qd = w_pq[utld_pkg::SH_675 +: utld_pkg::DAYS_W];

        w_r   = r_x - 26'(r_qd) * 26'd675;
        n_rem = {w_r[9:0], r_lo};
        n_z   = utld_pkg::Z_W'(r_qd) + utld_pkg::Z_SHIFT;

        w_ph     = 35'(r_rem) * 35'(utld_pkg::MUL_3600);
        n_hour_1 = w_ph[utld_pkg::SH_3600 +: utld_pkg::HOUR_W];

        n_mr_2 = 12'(r_rem_h1 - utld_pkg::SOD_W'(r_hour_1) * utld_pkg::SOD_W'(3600));

        w_pmin   = 25'(r_mr_2) * 25'(utld_pkg::MUL_60);
        n_minute = w_pmin[utld_pkg::SH_60 +: utld_pkg::MINUTE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_biased <= n_biased;
            r_x      <= r_biased[BW-1:7];
            r_lo     <= r_biased[6:0];
            r_qd     <= n_qd;
            r_rem    <= n_rem;
            r_z      <= n_z;

            r_rem_h1 <= r_rem;
            r_hour_1 <= n_hour_1;
            r_hour_2 <= r_hour_1;
            r_mr_2   <= n_mr_2;

            r_hm_dly[0] <= '{hour: r_hour_2, minute: n_minute};
            for (int k = 1; k <= utld_pkg::HM_DLY; k++) begin
                r_hm_dly[k] <= r_hm_dly[k-1];
            end
        end
    end

    utld_civil u_civil (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_z     (r_z),
        .o_year  (o_out.year),
        .o_month (o_out.month),
        .o_day   (o_out.day)
    );

    assign o_out.valid  = r_vld[LAT-1];
    assign o_out.hour   = r_hm_dly[utld_pkg::HM_DLY].hour;
    assign o_out.minute = r_hm_dly[utld_pkg::HM_DLY].minute;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_STAMPS = 800;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 3 * utld_pkg::LATENCY;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AT_WORD  = 120;
    localparam int MAX_REPORTS   = 10;

    localparam longint DAY_SECS   = 86400;
    localparam longint HOUR_SECS  = 3600;
    localparam longint SHIFT_DAYS = 719468;
    localparam longint ERA_LEN    = 146097;

    typedef struct packed {
        logic        [utld_pkg::EPOCH_W-1:0] epoch;
        logic signed [utld_pkg::ZONE_W-1:0]  zone;
    } t_stamp;

    typedef struct packed {
        logic [utld_pkg::YEAR_W-1:0]   year;
        logic [utld_pkg::MONTH_W-1:0]  month;
        logic [utld_pkg::DAY_W-1:0]    day;
        logic [utld_pkg::HOUR_W-1:0]   hour;
        logic [utld_pkg::MINUTE_W-1:0] minute;
    } t_local_date;

    logic i_clk = 1'b0;
    logic i_rst_n;

    utld_in_if  in_if();
    utld_out_if out_if();

    unix_time_to_local_date_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    t_stamp      stamps_to_send[$];
    t_local_date dates_due[$];

    int  n_directed  = 0;
    int  n_accepted  = 0;
    int  n_results   = 0;
    int  n_errors    = 0;
    int  in_stalls   = 0;
    int  cycles      = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  in_fire     = 1'b0;

    // Local calendar date and time for a Unix time shifted by a zone offset.
    function automatic t_local_date civil_date_at(logic [utld_pkg::EPOCH_W-1:0] epoch,
                                                  logic signed [utld_pkg::ZONE_W-1:0] zone);
        t_local_date r;
        longint secs, days, sod, z, era, doe, yoe, doy, mp, mon;
        secs = longint'($signed({1'b0, epoch})) + longint'(zone) * 60;
        days = secs / DAY_SECS;
        sod  = secs % DAY_SECS;
        // floor toward minus infinity, so negative whole days give hour 0
        if (sod < 0) begin
            sod  = sod + DAY_SECS;
            days = days - 1;
        end
        z   = days + SHIFT_DAYS;
        era = z / ERA_LEN;
        doe = z - era * ERA_LEN;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        r.day    = utld_pkg::DAY_W'(doy - (153 * mp + 2) / 5 + 1);
        r.month  = utld_pkg::MONTH_W'(mon);
        r.year   = utld_pkg::YEAR_W'(yoe + era * 400 + ((mon <= 2) ? 1 : 0));
        r.hour   = utld_pkg::HOUR_W'(sod / HOUR_SECS);
        r.minute = utld_pkg::MINUTE_W'((sod % HOUR_SECS) / 60);
        return r;
    endfunction

    function automatic void add_stamp(logic [utld_pkg::EPOCH_W-1:0] epoch,
                                      logic signed [utld_pkg::ZONE_W-1:0] zone);
        t_stamp s;
        s.epoch = epoch;
        s.zone  = zone;
        stamps_to_send.push_back(s);
    endfunction

    // phase 0: sender idles 30%, receiver 81%; phase 1 swapped; phase 2 no idling
    function automatic int sender_idle_pct(int n);
        if (n < 300) return 30;
        if (n < 560) return 81;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int n);
        if (n < 300) return 81;
        if (n < 560) return 30;
        return 0;
    endfunction

    task automatic report_miss(string what, t_local_date want, t_local_date got);
        if (n_errors < MAX_REPORTS)
            $display("ERROR %s: expected %0d-%0d-%0d %0d:%0d, got %0d-%0d-%0d %0d:%0d",
                     what, want.year, want.month, want.day, want.hour, want.minute,
                     got.year, got.month, got.day, got.hour, got.minute);
        n_errors++;
    endtask

    // Driver: advance to the next word once the current one is taken.
    always @(negedge i_clk) begin : driver
        t_stamp s;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fire) begin
            if (stamps_to_send.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(n_accepted)) begin
                s = stamps_to_send.pop_front();
                in_if.valid               <= 1'b1;
                in_if.epoch_seconds       <= s.epoch;
                in_if.zone_offset_minutes <= s.zone;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Long output hold-off once, so the pipeline fills and stalls its input.
    always @(negedge i_clk) begin : hold_off
        if (i_rst_n) begin
            if (!hold_done && n_accepted >= HOLD_AT_WORD) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= (hold_left == 0) &&
                            ($urandom_range(99) >= receiver_idle_pct(n_accepted));
    end

    always @(posedge i_clk) begin : monitor
        t_local_date got, want;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, dates_due.size());
            $display("status: fail");
            $finish;
        end
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_if.valid && in_if.ready;
            if (in_if.valid && !in_if.ready)
                in_stalls <= in_stalls + 1;
            if (in_if.valid && in_if.ready) begin
                dates_due.push_back(civil_date_at(in_if.epoch_seconds,
                                                  in_if.zone_offset_minutes));
                n_accepted <= n_accepted + 1;
            end
            if (out_if.valid && out_if.ready) begin
                got.year   = out_if.year;
                got.month  = out_if.month;
                got.day    = out_if.day;
                got.hour   = out_if.hour;
                got.minute = out_if.minute;
                n_results <= n_results + 1;
                if (dates_due.size() == 0) begin
                    report_miss("result with nothing pending", got, got);
                end else begin
                    want = dates_due.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.hour !== want.hour ||
                        got.minute !== want.minute)
                        report_miss("date mismatch", want, got);
                end
            end
        end
    end

    initial begin : stimulus
        logic [utld_pkg::EPOCH_W-1:0]       e;
        logic signed [utld_pkg::ZONE_W-1:0] z;
        int kind;

        i_rst_n                   = 1'b0;
        in_if.valid               = 1'b0;
        in_if.epoch_seconds       = '0;
        in_if.zone_offset_minutes = '0;
        out_if.ready              = 1'b0;

        // epoch start and field extremes
        add_stamp(32'd0, 16'sd0);
        add_stamp(32'd0, -16'sd1);
        add_stamp(32'd0, -16'sd32768);
        add_stamp(32'd0, 16'sd32767);
        add_stamp(32'hFFFF_FFFF, 16'sd0);
        add_stamp(32'hFFFF_FFFF, 16'sd32767);
        add_stamp(32'hFFFF_FFFF, -16'sd32768);
        add_stamp(32'h8000_0000, 16'sd0);
        add_stamp(32'h7FFF_FFFF, 16'sd0);
        add_stamp(32'hAAAA_AAAA, 16'sh5555);
        add_stamp(32'h5555_5555, 16'shAAAA);
        // negative whole days land on hour 0, never 24
        add_stamp(32'd0, -16'sd1440);
        add_stamp(32'd0, -16'sd2880);
        add_stamp(32'd86400, -16'sd1440);
        add_stamp(32'd86340, -16'sd1440);
        // leap-year and century edges
        add_stamp(32'd68169600, 16'sd0);
        add_stamp(32'd951782400, 16'sd0);
        add_stamp(32'd951868800, -16'sd1);
        add_stamp(32'd4107456000, 16'sd0);
        add_stamp(32'd4107542400, 16'sd0);
        add_stamp(32'd4102444799, 16'sd60);
        n_directed = stamps_to_send.size();

        for (int i = 0; i < RANDOM_STAMPS; i++) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                e = $urandom;
                z = $urandom;
            end else if (kind < 70) begin
                // real-world zones: quarter hours from -12:00 to +14:00
                e = $urandom;
                z = utld_pkg::ZONE_W'(($signed($urandom_range(104)) - 48) * 15);
            end else if (kind < 90) begin
                // near midnight, with whole-day offsets
                e = utld_pkg::EPOCH_W'(longint'($urandom_range(49710)) * DAY_SECS +
                                       $urandom_range(120) - 60);
                z = utld_pkg::ZONE_W'(($signed($urandom_range(44)) - 22) * 1440);
            end else begin
                e = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(200000)
                                      : utld_pkg::EPOCH_W'($urandom_range(200000));
                z = $urandom_range(1) ? 16'sh8000 + utld_pkg::ZONE_W'($urandom_range(255))
                                      : 16'sh7FFF - utld_pkg::ZONE_W'($urandom_range(255));
            end
            add_stamp(e, z);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stamps_to_send.size() != 0 || in_if.valid) @(posedge i_clk);
        while (dates_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (dates_due.size() != 0) begin
            $display("ERROR %0d results never arrived", dates_due.size());
            n_errors++;
        end
        $display("sent %0d timestamps (%0d directed), checked %0d dates, %0d errors",
                 n_accepted, n_directed, n_results, n_errors);
        $display("input stalled %0d cycles under a %0d-cycle output hold-off",
                 in_stalls, HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
